FILE: rtl/rpdt_pkg.sv
// Shared types and constants for the prescaled reload down-timer.
package rpdt_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SEL_RELOAD  = 2'd0,
    SEL_COUNT   = 2'd1,
    SEL_CONTROL = 2'd2,
    SEL_NONE    = 2'd3
  } sel_e;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_RELOAD = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_IRQ    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic {
    CTL_EMPTY = 1'b0,
    CTL_FULL  = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic exec;
    op_e  op;
  } cmd_t;

  localparam int unsigned DataW     = 16;
  localparam int unsigned CtrlW     = 8;
  localparam int unsigned PrescW    = 7;

  localparam logic [DataW-1:0] ResetReload = 16'o011000;
  localparam logic [DataW-1:0] ResetCount  = 16'o177777;
  localparam logic [CtrlW-1:0] CtrlHigh    = 8'hFF;
  localparam int unsigned      CtrlIrqBit  = 2;
  localparam int unsigned      CtrlFreeBit = 1;

endpackage

FILE: rtl/rpdt_if.sv
// Handshake interfaces for the timer's input and result channels.
interface rpdt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [1:0]                  reg_sel;
  logic [rpdt_pkg::DataW-1:0]  write_data;

  modport source (output valid, output kind, output reg_sel, output write_data, input ready);
  modport sink   (input valid, input kind, input reg_sel, input write_data, output ready);
endinterface

interface rpdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpdt_pkg::DataW-1:0]  read_data;
  logic                        irq_pulse;

  modport source (output valid, output read_data, output irq_pulse, input ready);
  modport sink   (input valid, input read_data, input irq_pulse, output ready);
endinterface

FILE: rtl/rpdt_ctrl.sv
// Controller: output-register occupancy and per-transaction command decode.
module rpdt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_kind_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output rpdt_pkg::cmd_t cmd_o
);

  rpdt_pkg::ctl_state_e state_q, state_d;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpdt_pkg::CTL_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpdt_pkg::CTL_EMPTY: begin
        if (in_valid_i) state_d = rpdt_pkg::CTL_FULL;
      end
      rpdt_pkg::CTL_FULL: begin
        if (out_ready_i && !in_valid_i) state_d = rpdt_pkg::CTL_EMPTY;
      end
      default: state_d = rpdt_pkg::CTL_EMPTY;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      rpdt_pkg::CTL_EMPTY: begin
        in_ready_o = 1'b1;
      end
      rpdt_pkg::CTL_FULL: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    accept      = in_valid_i && in_ready_o;
    cmd_o.exec  = accept;
    case (in_kind_i)
      rpdt_pkg::KIND_TICK:  cmd_o.op = rpdt_pkg::OP_TICK;
      rpdt_pkg::KIND_READ:  cmd_o.op = rpdt_pkg::OP_READ;
      rpdt_pkg::KIND_WRITE: cmd_o.op = rpdt_pkg::OP_WRITE;
      default:              cmd_o.op = rpdt_pkg::OP_IDLE;
    endcase
  end

endmodule

FILE: rtl/rpdt_datapath.sv
// Datapath: timer registers, prescaler, down-counter and result register.
module rpdt_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpdt_pkg::cmd_t             cmd_i,
  input  logic [1:0]                 reg_sel_i,
  input  logic [rpdt_pkg::DataW-1:0] write_data_i,
  output logic [rpdt_pkg::DataW-1:0] read_data_o,
  output logic                       irq_pulse_o
);

  logic [rpdt_pkg::DataW-1:0]  reload_q, reload_d;
  logic [rpdt_pkg::DataW-1:0]  count_q, count_d;
  logic [rpdt_pkg::CtrlW-1:0]  ctrl_q, ctrl_d;
  rpdt_pkg::mode_e             mode_q, mode_d;
  logic [rpdt_pkg::PrescW-1:0] presc_q, presc_d;
  logic                        pend_q, pend_d;
  logic [rpdt_pkg::DataW-1:0]  rd_q, rd_d;
  logic                        irq_q, irq_d;

  logic [rpdt_pkg::PrescW-1:0] presc_inc;
  logic [rpdt_pkg::PrescW-1:0] divisor;
  logic [3:0]                  nib;
  logic                        fire;
  logic [rpdt_pkg::DataW-1:0]  count_dec;

  always_comb begin
    nib       = ctrl_q[rpdt_pkg::CtrlW-1:4];
    divisor   = (nib == 4'd0) ? 7'd1 : {nib, 3'b000};
    presc_inc = presc_q + 7'd1;
    fire      = presc_inc >= divisor;
    count_dec = count_q - 16'd1;
  end

  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    mode_d   = mode_q;
    presc_d  = presc_q;
    pend_d   = pend_q;
    rd_d     = '0;
    irq_d    = 1'b0;
    case (cmd_i.op)
      rpdt_pkg::OP_TICK: begin
        if (!fire) begin
          presc_d = presc_inc;
        end else begin
          presc_d = '0;
          case (mode_q)
            rpdt_pkg::MODE_RELOAD, rpdt_pkg::MODE_IRQ: begin
              if (pend_q) begin
                pend_d  = 1'b0;
                count_d = reload_q;
              end else begin
                count_d = count_dec;
                if (count_dec == 16'd1) begin
                  pend_d = 1'b1;
                  irq_d  = (mode_q == rpdt_pkg::MODE_IRQ);
                end
              end
            end
            rpdt_pkg::MODE_FREE: count_d = count_dec;
            default: count_d = count_q;
          endcase
        end
      end
      rpdt_pkg::OP_READ: begin
        case (reg_sel_i)
          rpdt_pkg::SEL_RELOAD:  rd_d = reload_q;
          rpdt_pkg::SEL_COUNT:   rd_d = count_q;
          rpdt_pkg::SEL_CONTROL: rd_d = {rpdt_pkg::CtrlHigh, ctrl_q};
          default:               rd_d = '0;
        endcase
      end
      rpdt_pkg::OP_WRITE: begin
        case (reg_sel_i)
          rpdt_pkg::SEL_RELOAD: reload_d = write_data_i;
          rpdt_pkg::SEL_COUNT:  count_d  = write_data_i;
          rpdt_pkg::SEL_CONTROL: begin
            count_d = reload_q;
            ctrl_d  = write_data_i[rpdt_pkg::CtrlW-1:0];
            if (write_data_i[rpdt_pkg::CtrlIrqBit]) begin
              mode_d = rpdt_pkg::MODE_IRQ;
            end else if (write_data_i[rpdt_pkg::CtrlFreeBit]) begin
              mode_d = rpdt_pkg::MODE_FREE;
            end else begin
              mode_d = rpdt_pkg::MODE_RELOAD;
            end
          end
          default: reload_d = reload_q;
        endcase
      end
      default: rd_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= rpdt_pkg::ResetReload;
      count_q  <= rpdt_pkg::ResetCount;
      ctrl_q   <= '0;
      mode_q   <= rpdt_pkg::MODE_STOP;
      presc_q  <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.exec) begin
      reload_q <= reload_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      mode_q   <= mode_d;
      presc_q  <= presc_d;
      pend_q   <= pend_d;
    end
  end

  // Result register: loaded once per accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign read_data_o = rd_q;
  assign irq_pulse_o = irq_q;

endmodule

FILE: rtl/prescaled_reload_down_timer_core.sv
// Top level of the prescaled reload down-timer.
//
//   port   dir  payload                        transaction
//   in_i   in   kind, reg_sel, write_data      tick, register read or write
//   out_o  out  read_data, irq_pulse           one result per input
//
// Each transaction is executed in the cycle it is accepted; its result sits in
// the output register from the next cycle on. Rate is one per cycle unless stalled.
// in_i.ready stays high while the output register is empty or being drained,
// so a stalled result holds the input back only until out_o.ready returns.
// Reset is asynchronous, active low; the timer stays stopped until a control write.
module prescaled_reload_down_timer_core (
  input  logic clk_i,
  input  logic rst_ni,
  rpdt_in_if.sink    in_i,
  rpdt_out_if.source out_o
);

  rpdt_pkg::cmd_t cmd;

  rpdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  rpdt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .reg_sel_i    (in_i.reg_sel),
    .write_data_i (in_i.write_data),
    .read_data_o  (out_o.read_data),
    .irq_pulse_o  (out_o.irq_pulse)
  );

endmodule

FILE: rtl/rpdt_checker.sv
// Port-level checker for the timer core, attached by bind.
module rpdt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [1:0]                 in_kind_i,
  input logic [1:0]                 in_reg_sel_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rpdt_pkg::DataW-1:0] out_read_data_i,
  input logic                       out_irq_pulse_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Every accepted transaction produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("result missing after accepted transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_read_data_i)
      && $stable(out_irq_pulse_i))
    else $error("stalled result changed");

  // Control reads always show FF in the high byte
  a_ctrl_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_kind_i == rpdt_pkg::KIND_READ && in_reg_sel_i == rpdt_pkg::SEL_CONTROL
      |=> out_read_data_i[15:8] == rpdt_pkg::CtrlHigh)
    else $error("control read lost high byte");

  // An interrupt only comes from a tick, which returns no read data
  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_irq_pulse_i |-> out_read_data_i == '0)
    else $error("interrupt result carries read data");

endmodule

bind prescaled_reload_down_timer_core rpdt_checker u_rpdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_kind_i       (in_i.kind),
  .in_reg_sel_i    (in_i.reg_sel),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data),
  .out_irq_pulse_i (out_o.irq_pulse)
);

FILE: test/rpdt_timer_checker.sv
// Checker for the down-timer: tracks timer state per transaction and compares every result.
module rpdt_timer_checker
  import rpdt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rpdt_in_if   in_mon,
  rpdt_out_if  out_mon,
  output int   fail_count_o,
  output int   open_count_o,
  output int   irq_count_o
);

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_pulse;
  } bus_reply_t;

  logic [DataW-1:0]  reload_q;
  logic [DataW-1:0]  count_q;
  logic [CtrlW-1:0]  ctl_q;
  mode_e             mode_q;
  logic [PrescW-1:0] presc_q;
  logic              pend_q;

  bus_reply_t bus_replies[$];
  int         fails = 0;
  int         irqs = 0;
  int         n_results = 0;

  assign fail_count_o = fails;
  assign irq_count_o  = irqs;

  task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
    $display("%0t: result %0d %s: got %h, expected %h", $time, n_results, what, got, want);
    fails++;
  endtask

  // Advance the timer state by one transaction and return the reply it owes.
  function automatic bus_reply_t timer_step(kind_e k, sel_e s, logic [DataW-1:0] d);
    bus_reply_t        r;
    logic [PrescW-1:0] nxt;
    int unsigned       div;
    r = '0;
    case (k)
      KIND_TICK: begin
        nxt = presc_q + 1'b1;
        div = (ctl_q[7:4] == 4'd0) ? 1 : 8 * ctl_q[7:4];
        if (nxt < div) begin
          presc_q = nxt;
        end else begin
          presc_q = '0;
          if (mode_q == MODE_RELOAD || mode_q == MODE_IRQ) begin
            if (pend_q) begin
              pend_q  = 1'b0;
              count_q = reload_q;
            end else begin
              count_q = count_q - 1'b1;
              if (count_q == 16'd1) begin
                pend_q = 1'b1;
                r.irq_pulse = (mode_q == MODE_IRQ);
              end
            end
          end else if (mode_q == MODE_FREE) begin
            count_q = count_q - 1'b1;
          end
        end
      end
      KIND_READ: begin
        case (s)
          SEL_RELOAD:  r.read_data = reload_q;
          SEL_COUNT:   r.read_data = count_q;
          SEL_CONTROL: r.read_data = {CtrlHigh, ctl_q};
          default:     r.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (s)
          SEL_RELOAD: reload_q = d;
          SEL_COUNT:  count_q = d;
          SEL_CONTROL: begin
            // control write restarts the count from the reload value
            count_q = reload_q;
            ctl_q   = d[CtrlW-1:0];
            if (d[CtrlIrqBit])       mode_q = MODE_IRQ;
            else if (d[CtrlFreeBit]) mode_q = MODE_FREE;
            else                     mode_q = MODE_RELOAD;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_reply_t want;
    if (!rst_ni) begin
      reload_q = ResetReload;
      count_q  = ResetCount;
      ctl_q    = '0;
      mode_q   = MODE_STOP;
      presc_q  = '0;
      pend_q   = 1'b0;
      bus_replies.delete();
    end else begin
      // drain first: a result leaving now belongs to an earlier transaction
      if (out_mon.valid && out_mon.ready) begin
        n_results++;
        if (bus_replies.size() == 0) begin
          report_mismatch("arrived with nothing expected", out_mon.read_data, '0);
        end else begin
          want = bus_replies.pop_front();
          if (out_mon.read_data !== want.read_data)
            report_mismatch("read_data", out_mon.read_data, want.read_data);
          if (out_mon.irq_pulse !== want.irq_pulse)
            report_mismatch("irq_pulse", 16'(out_mon.irq_pulse), 16'(want.irq_pulse));
        end
        if (out_mon.irq_pulse === 1'b1) irqs++;
      end
      if (in_mon.valid && in_mon.ready)
        bus_replies.push_back(timer_step(kind_e'(in_mon.kind), sel_e'(in_mon.reg_sel),
                                         in_mon.write_data));
    end
    open_count_o = bus_replies.size();
  end

endmodule

FILE: test/tb_prescaled_reload_down_timer_core.sv
// Testbench top for the down-timer: reset, stimulus, handshake pressure and verdict.
module tb_prescaled_reload_down_timer_core;
  import rpdt_pkg::*;

  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned CalmFrom   = 1570;
  localparam int unsigned DrainAt    = 900;
  localparam int unsigned IdleLimit  = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpdt_in_if  in_if ();
  rpdt_out_if out_if ();

  int fails;
  int open_results;
  int irq_seen;
  int n_tick = 0;
  int n_read = 0;
  int n_write = 0;
  int n_none = 0;
  int items_sent = 0;
  int gap_odds = 0;
  int stall_odds = 0;
  int ready_hold = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit drained = 1'b0;

  prescaled_reload_down_timer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rpdt_timer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fails),
    .open_count_o (open_results),
    .irq_count_o  (irq_seen)
  );

  always #4 clk_i = ~clk_i;

  // Result-side back-pressure: random stall bursts, none in the last stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_if.ready <= 1'b0;
      ready_hold--;
    end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold = $urandom_range(1, 11) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles, %0d results open", idle_cycles,
               open_results);
      $display("prescaled_reload_down_timer_core test failed");
      $finish;
    end
  end

  task automatic send_item(kind_e k, sel_e s, logic [DataW-1:0] d);
    int gap;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      gap = $urandom_range(1, 11);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.reg_sel    <= s;
    in_if.write_data <= d;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    case (k)
      KIND_TICK:  n_tick++;
      KIND_READ:  n_read++;
      KIND_WRITE: n_write++;
      default:    n_none++;
    endcase
    if (k != KIND_NONE) items_sent++;
  endtask

  // Hold the sender until every open result has drained.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (open_results != 0);
  endtask

  // Program reload and control, then run a burst of ticks with reads and counter writes mixed in.
  task automatic timer_sequence();
    logic [DataW-1:0] reload_word;
    logic [DataW-1:0] ctl_word;
    logic [3:0]       nib;
    int               n;
    reload_word = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
    nib = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(2, 15)) : 4'($urandom_range(0, 1));
    ctl_word = {8'($urandom), nib, 4'($urandom)};
    send_item(KIND_WRITE, SEL_RELOAD, reload_word);
    send_item(KIND_WRITE, SEL_CONTROL, ctl_word);
    n = $urandom_range(8, 40);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_item(KIND_READ, sel_e'($urandom_range(0, 3)), 16'($urandom));
        1: begin
          if ($urandom_range(0, 3) == 0)
            send_item(KIND_WRITE, SEL_COUNT, 16'($urandom_range(0, 3)));
          else
            send_item(KIND_TICK, sel_e'($urandom_range(0, 3)), 16'($urandom));
        end
        default: send_item(KIND_TICK, sel_e'($urandom_range(0, 3)), 16'($urandom));
      endcase
    end
    send_item(KIND_READ, SEL_COUNT, 16'($urandom));
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_TICK;
    in_if.reg_sel    = SEL_RELOAD;
    in_if.write_data = '0;
    rst_ni           = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values and the unused selector
    send_item(KIND_READ, SEL_RELOAD, 16'h0000);
    send_item(KIND_READ, SEL_COUNT, 16'hFFFF);
    send_item(KIND_READ, SEL_CONTROL, 16'h0000);
    send_item(KIND_READ, SEL_NONE, 16'hFFFF);
    // stopped timer: tick leaves the count as it is
    send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    send_item(KIND_NONE, SEL_CONTROL, 16'hFFFF);
    send_item(KIND_WRITE, SEL_NONE, 16'hFFFF);
    send_item(KIND_READ, SEL_RELOAD, 16'h0000);
    // reload mode, every tick fires; high byte of control is dropped
    send_item(KIND_WRITE, SEL_RELOAD, 16'd3);
    send_item(KIND_WRITE, SEL_CONTROL, 16'hFF00);
    repeat (4) send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    send_item(KIND_READ, SEL_COUNT, 16'h0000);
    // interrupt mode: pulse when the count reaches one, reload after
    send_item(KIND_WRITE, SEL_CONTROL, 16'h0004);
    repeat (3) send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    // free-run wraps through zero
    send_item(KIND_WRITE, SEL_CONTROL, 16'h0002);
    send_item(KIND_WRITE, SEL_COUNT, 16'h0000);
    send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    // widest divisor, then shrink it below the prescale count
    send_item(KIND_WRITE, SEL_RELOAD, 16'hFFFF);
    send_item(KIND_WRITE, SEL_CONTROL, 16'h00FF);
    send_item(KIND_READ, SEL_CONTROL, 16'h0000);
    repeat (9) send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    send_item(KIND_WRITE, SEL_CONTROL, 16'h0010);
    send_item(KIND_TICK, SEL_RELOAD, 16'h0000);
    send_item(KIND_READ, SEL_COUNT, 16'h0000);

    while (items_sent < ItemTarget) begin
      calm = (items_sent >= CalmFrom);
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 12;
        default: gap_odds = 3;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_odds = 0;
        1:       stall_odds = 12;
        default: stall_odds = 3;
      endcase
      if (!drained && items_sent >= DrainAt) begin
        drain_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7)
        timer_sequence();
      else
        repeat ($urandom_range(1, 6))
          send_item(kind_e'($urandom_range(0, 3)), sel_e'($urandom_range(0, 3)),
                    16'($urandom));
    end

    drain_results();
    repeat (4) @(negedge clk_i);
    $display("covered %0d ticks, %0d reads, %0d writes, %0d unused-kind transactions",
             n_tick, n_read, n_write, n_none);
    $display("%0d interrupt pulses; stopped, reload, free-run and interrupt modes exercised",
             irq_seen);
    if (fails == 0)
      $display("prescaled_reload_down_timer_core test passed");
    else
      $display("prescaled_reload_down_timer_core test failed");
    $finish;
  end

endmodule

FILE: prescaled_reload_down_timer_core.f
rtl/rpdt_pkg.sv
rtl/rpdt_if.sv
rtl/rpdt_ctrl.sv
rtl/rpdt_datapath.sv
rtl/prescaled_reload_down_timer_core.sv
rtl/rpdt_checker.sv
test/rpdt_timer_checker.sv
test/tb_prescaled_reload_down_timer_core.sv
